/* hdl/nvme_queue_pair_tracker_macros.svh */
// Assertion shorthands for the tracker RTL.
`ifndef NVME_QUEUE_PAIR_TRACKER_MACROS_SVH
`define NVME_QUEUE_PAIR_TRACKER_MACROS_SVH

// Check a condition in the same cycle as its trigger.
`define NQPT_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check a condition in the cycle after its trigger.
`define NQPT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hdl/nqpt_pkg.sv */
`default_nettype none

package nqpt_pkg;

   localparam int ENTRY_W     = 8;
   localparam int QID_W       = 2;
   localparam int CFG_ENT_W   = 9;
   localparam int CFG_CNT_W   = 3;
   localparam int CSR_IDX_W   = 2;

   typedef enum logic [1:0] {
      FUNC_SUBMIT  = 2'd0,
      FUNC_CQE     = 2'd1,
      FUNC_RELEASE = 2'd2,
      FUNC_READ    = 2'd3
   } func_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_QUEUE_ENTRIES = 2'd0,
      CSR_QUEUE_COUNT   = 2'd1
   } csr_index_type;

   typedef enum logic [2:0] {
      FLAG_NONE     = 3'd0,
      FLAG_SUBMIT   = 3'd1,
      FLAG_COMPLETE = 3'd2,
      FLAG_RELEASE  = 3'd3,
      FLAG_READ     = 3'd4
   } flag_op_type;

   typedef struct packed {
      logic in_flight;
      logic pending;
   } flags_type;

   typedef struct packed {
      logic [14:0] status;
      logic [15:0] sq_head;
      logic [31:0] dword0;
   } cpl_type;

   // Decision taken at accept time, carried into the memory stage.
   typedef struct packed {
      logic               accepted;
      logic               range_error;
      logic [ENTRY_W-1:0] slot_out;
      logic [ENTRY_W-1:0] doorbell;
      flag_op_type        flag_op;
      logic               cpl_write;
      logic [QID_W-1:0]   tgt_queue;
      logic [ENTRY_W-1:0] tgt_slot;
   } qdec_type;

endpackage

`default_nettype wire

/* hdl/nqpt_ram.sv */
`default_nettype none

module nqpt_ram #(
   parameter int WIDTH  = 2,
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              we,
   input  wire logic [ADDR_W-1:0] waddr,
   input  wire logic [WIDTH-1:0]  wdata,
   input  wire logic [ADDR_W-1:0] raddr,
   output logic      [WIDTH-1:0]  rdata_ff
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      rdata_ff <= mem[raddr];
   end

endmodule

`default_nettype wire

/* hdl/nqpt_queue_regs.sv */
`default_nettype none

module nqpt_queue_regs #(
   parameter int QUEUES = 4,
   parameter int SLOTS  = 256
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         fire,
   input  wire nqpt_pkg::func_type           func,
   input  wire logic [nqpt_pkg::QID_W-1:0]   queue_id,
   input  wire logic [nqpt_pkg::ENTRY_W-1:0] slot,
   input  wire logic                         cqe_phase,
   input  wire logic [nqpt_pkg::QID_W-1:0]   cqe_sq_id,
   input  wire logic [nqpt_pkg::ENTRY_W-1:0] cqe_cmd_id,
   input  wire logic [nqpt_pkg::CFG_ENT_W-1:0] queue_entries,
   input  wire logic [nqpt_pkg::CFG_CNT_W-1:0] queue_count,
   output nqpt_pkg::qdec_type                dec
);

   import nqpt_pkg::*;

   localparam int QIW = (QUEUES > 1) ? $clog2(QUEUES) : 1;
   localparam int QCW = ($clog2(QUEUES + 1) > CFG_CNT_W) ? $clog2(QUEUES + 1) : CFG_CNT_W;
   localparam int LIM = (SLOTS < 256) ? SLOTS : 256;

   logic [ENTRY_W-1:0] tail_ff  [QUEUES];
   logic [ENTRY_W-1:0] head_ff  [QUEUES];
   logic               phase_ff [QUEUES];

   logic [ENTRY_W-1:0]   tail_in;
   logic [ENTRY_W-1:0]   head_in;
   logic                 phase_in;
   logic                 tail_we;
   logic                 head_we;
   logic [CFG_ENT_W-1:0] ent;
   logic [QCW-1:0]       qc;
   logic [QCW-1:0]       nq;
   logic [QIW-1:0]       qi;
   logic                 q_ok;
   logic                 tgt_ok;
   logic                 slot_ok;

   function automatic logic [ENTRY_W-1:0] advance(input logic [ENTRY_W-1:0] p,
                                                  input logic [CFG_ENT_W-1:0] e);
      logic [CFG_ENT_W-1:0] n;
      n = CFG_ENT_W'(p) + CFG_ENT_W'(1);
      return (n >= e) ? '0 : n[ENTRY_W-1:0];
   endfunction

   // Clamp the ring size and the queue count to their usable ranges.
   always_comb begin
      if (queue_entries < CFG_ENT_W'(2)) begin
         ent = CFG_ENT_W'(2);
      end else if (queue_entries > CFG_ENT_W'(LIM)) begin
         ent = CFG_ENT_W'(LIM);
      end else begin
         ent = queue_entries;
      end
   end

   always_comb begin
      qc = QCW'(queue_count);
      if (qc == '0) begin
         nq = QCW'(1);
      end else if (qc > QCW'(QUEUES)) begin
         nq = QCW'(QUEUES);
      end else begin
         nq = qc;
      end
   end

   assign qi      = QIW'(queue_id);
   assign q_ok    = QCW'(queue_id) < nq;
   assign tgt_ok  = (QCW'(cqe_sq_id) < nq) && (CFG_ENT_W'(cqe_cmd_id) < ent);
   assign slot_ok = CFG_ENT_W'(slot) < ent;

   assign tail_in  = advance(tail_ff[qi], ent);
   assign head_in  = advance(head_ff[qi], ent);
   assign phase_in = (head_in == '0) ? ~phase_ff[qi] : phase_ff[qi];

   always_comb begin
      dec     = '0;
      tail_we = 1'b0;
      head_we = 1'b0;
      if (!q_ok) begin
         dec.range_error = 1'b1;
      end else begin
         unique case (func)
            FUNC_SUBMIT: begin
               tail_we       = 1'b1;
               dec.accepted  = 1'b1;
               dec.slot_out  = tail_ff[qi];
               dec.doorbell  = tail_in;
               dec.flag_op   = FLAG_SUBMIT;
               dec.tgt_queue = queue_id;
               dec.tgt_slot  = tail_ff[qi];
            end
            FUNC_CQE: begin
               if (cqe_phase == phase_ff[qi]) begin
                  head_we      = 1'b1;
                  dec.accepted = 1'b1;
                  dec.doorbell = head_in;
                  if (tgt_ok) begin
                     dec.flag_op   = FLAG_COMPLETE;
                     dec.cpl_write = 1'b1;
                     dec.tgt_queue = cqe_sq_id;
                     dec.tgt_slot  = cqe_cmd_id;
                  end else begin
                     dec.range_error = 1'b1;
                  end
               end
            end
            FUNC_RELEASE: begin
               if (slot_ok) begin
                  dec.accepted  = 1'b1;
                  dec.flag_op   = FLAG_RELEASE;
                  dec.tgt_queue = queue_id;
                  dec.tgt_slot  = slot;
               end else begin
                  dec.range_error = 1'b1;
               end
            end
            FUNC_READ: begin
               if (slot_ok) begin
                  dec.accepted  = 1'b1;
                  dec.slot_out  = slot;
                  dec.flag_op   = FLAG_READ;
                  dec.tgt_queue = queue_id;
                  dec.tgt_slot  = slot;
               end else begin
                  dec.range_error = 1'b1;
               end
            end
            default: begin
               dec.range_error = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < QUEUES; i++) begin
            tail_ff[i]  <= '0;
            head_ff[i]  <= '0;
            phase_ff[i] <= 1'b1;
         end
      end else if (fire) begin
         if (tail_we) begin
            tail_ff[qi] <= tail_in;
         end
         if (head_we) begin
            head_ff[qi]  <= head_in;
            phase_ff[qi] <= phase_in;
         end
      end
   end

endmodule

`default_nettype wire

/* hdl/nvme_queue_pair_tracker.sv */
`default_nettype none
`include "nvme_queue_pair_tracker_macros.svh"

// The result strobe rsp_valid rises the cycle after start is taken.
// A new item is not taken while the last one is in its stage, for the read-modify-write of the slot flag memory.
// Reset: synchronous; busy stays high through reset and then while a sweep clears every
// entry of the flag memory; configuration writes are taken during the sweep.
// The receiver cannot stall; every result shows for exactly one cycle.

module nvme_queue_pair_tracker #(
   parameter int QUEUES = 4,
   parameter int SLOTS  = 256
) (
   input  wire logic                           clock,
   input  wire logic                           reset,

   input  wire logic                           start,
   output logic                                busy,
   input  wire logic [1:0]                     req_func,
   input  wire logic [nqpt_pkg::QID_W-1:0]     req_queue_id,
   input  wire logic [nqpt_pkg::ENTRY_W-1:0]   req_slot,
   input  wire logic                           req_cqe_phase,
   input  wire logic [nqpt_pkg::QID_W-1:0]     req_cqe_sq_id,
   input  wire logic [nqpt_pkg::ENTRY_W-1:0]   req_cqe_cmd_id,
   input  wire logic [31:0]                    req_cqe_dword0,
   input  wire logic [15:0]                    req_cqe_sq_head,
   input  wire logic [14:0]                    req_cqe_status,

   output logic                                rsp_valid,
   output logic [nqpt_pkg::ENTRY_W-1:0]        rsp_slot_out,
   output logic [nqpt_pkg::ENTRY_W-1:0]        rsp_doorbell_value,
   output logic                                rsp_accepted,
   output logic                                rsp_range_error,
   output logic                                rsp_slot_was_busy,
   output logic                                rsp_still_pending,
   output logic                                rsp_in_flight,
   output logic [31:0]                         rsp_result_dword0,
   output logic [15:0]                         rsp_result_sq_head,
   output logic [14:0]                         rsp_result_status,

   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [nqpt_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [nqpt_pkg::CFG_ENT_W-1:0] csr_wdata
);

   import nqpt_pkg::*;

   localparam int DEPTH = QUEUES * SLOTS;
   localparam int AW    = $clog2(DEPTH);
   localparam int FW    = $bits(flags_type);
   localparam int CW    = $bits(cpl_type);

   // Configuration registers.
   logic [CFG_ENT_W-1:0] entries_ff;
   logic [CFG_CNT_W-1:0] count_ff;

   // Clearing sweep over the flag memory after reset.
   logic          clr_active_ff;
   logic          clr_active_in;
   logic [AW-1:0] clr_addr_ff;
   logic [AW-1:0] clr_addr_in;
   logic          clr_last;

   // Memory stage: one item held while its flags come back.
   logic          stage_valid_ff;
   logic          stage_valid_in;
   qdec_type      dec_ff;
   logic [AW-1:0] addr_ff;

   qdec_type      dec;
   logic          fire;
   logic [AW-1:0] tgt_addr;

   logic          flag_we;
   logic [AW-1:0] flag_wa;
   flags_type     flag_wd;
   logic [FW-1:0] flag_rd_raw;
   flags_type     flag_rd;

   cpl_type       cpl_wd;
   logic [CW-1:0] cpl_rd_raw;
   cpl_type       cpl_rd;

   // ---------------------------------------------------------------
   // Handshake: take an item only when no sweep runs and the stage is free.
   // ---------------------------------------------------------------
   assign busy           = reset | clr_active_ff | stage_valid_ff;
   assign fire           = start & ~busy;
   assign stage_valid_in = fire;

   // ---------------------------------------------------------------
   // Configuration port: always ready outside reset; ignore unknown indexes.
   // ---------------------------------------------------------------
   assign csr_ready = ~reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         entries_ff <= CFG_ENT_W'(256);
         count_ff   <= CFG_CNT_W'(1);
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_QUEUE_ENTRIES: entries_ff <= csr_wdata;
            CSR_QUEUE_COUNT:   count_ff   <= csr_wdata[CFG_CNT_W-1:0];
            default: begin
               entries_ff <= entries_ff;
            end
         endcase
      end
   end

   // ---------------------------------------------------------------
   // Per-queue pointers and phases: decide the item and advance pointers
   // at the accept edge.
   // ---------------------------------------------------------------
   nqpt_queue_regs #(
      .QUEUES (QUEUES),
      .SLOTS  (SLOTS)
   ) u_queue_regs (
      .clock         (clock),
      .reset         (reset),
      .fire          (fire),
      .func          (func_type'(req_func)),
      .queue_id      (req_queue_id),
      .slot          (req_slot),
      .cqe_phase     (req_cqe_phase),
      .cqe_sq_id     (req_cqe_sq_id),
      .cqe_cmd_id    (req_cqe_cmd_id),
      .queue_entries (entries_ff),
      .queue_count   (count_ff),
      .dec           (dec)
   );

   // Flat slot address: queue-major, SLOTS entries per queue.
   assign tgt_addr = AW'(AW'(dec.tgt_queue) * AW'(SLOTS) + AW'(dec.tgt_slot));

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         dec_ff  <= dec;
         addr_ff <= tgt_addr;
      end
   end

   // ---------------------------------------------------------------
   // Clearing sweep: one flag entry per cycle after reset.
   // ---------------------------------------------------------------
   assign clr_last      = clr_addr_ff == AW'(DEPTH - 1);
   assign clr_active_in = clr_active_ff & ~clr_last;
   assign clr_addr_in   = clr_addr_ff + AW'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_active_ff <= 1'b1;
         clr_addr_ff   <= '0;
      end else if (clr_active_ff) begin
         clr_active_ff <= clr_active_in;
         clr_addr_ff   <= clr_addr_in;
      end
   end

   // ---------------------------------------------------------------
   // Flag memory: read at accept, modify and write back in the stage cycle.
   // The next item is accepted only after the write, so no forwarding.
   // ---------------------------------------------------------------
   assign flag_rd = flags_type'(flag_rd_raw);

   always_comb begin
      flag_we = 1'b0;
      flag_wa = addr_ff;
      flag_wd = '0;
      if (clr_active_ff) begin
         flag_we = 1'b1;
         flag_wa = clr_addr_ff;
      end else if (stage_valid_ff) begin
         case (dec_ff.flag_op)
            FLAG_SUBMIT: begin
               flag_we = 1'b1;
               flag_wd = '{in_flight: 1'b1, pending: 1'b1};
            end
            FLAG_COMPLETE: begin
               flag_we = 1'b1;
               flag_wd = '{in_flight: flag_rd.in_flight, pending: 1'b0};
            end
            FLAG_RELEASE: begin
               flag_we = 1'b1;
               flag_wd = '{in_flight: 1'b0, pending: flag_rd.pending};
            end
            default: begin
               flag_we = 1'b0;
            end
         endcase
      end
   end

   nqpt_ram #(
      .WIDTH (FW),
      .DEPTH (DEPTH)
   ) u_flag_ram (
      .clock    (clock),
      .we       (flag_we),
      .waddr    (flag_wa),
      .wdata    (flag_wd),
      .raddr    (tgt_addr),
      .rdata_ff (flag_rd_raw)
   );

   // ---------------------------------------------------------------
   // Completion memory: store an accepted, in-range entry at the accept edge, read
   // a slot for a read item at the same edge.
   // ---------------------------------------------------------------
   assign cpl_wd = '{status: req_cqe_status, sq_head: req_cqe_sq_head,
                     dword0: req_cqe_dword0};
   assign cpl_rd = cpl_type'(cpl_rd_raw);

   nqpt_ram #(
      .WIDTH (CW),
      .DEPTH (DEPTH)
   ) u_cpl_ram (
      .clock    (clock),
      .we       (fire & dec.cpl_write),
      .waddr    (tgt_addr),
      .wdata    (cpl_wd),
      .raddr    (tgt_addr),
      .rdata_ff (cpl_rd_raw)
   );

   // ---------------------------------------------------------------
   // Result: drive from the stage registers and memory read data;
   // zero the read fields for every item but a read.
   // ---------------------------------------------------------------
   logic is_read;
   logic is_submit;

   assign is_read   = dec_ff.flag_op == FLAG_READ;
   assign is_submit = dec_ff.flag_op == FLAG_SUBMIT;

   assign rsp_valid          = stage_valid_ff;
   assign rsp_slot_out       = dec_ff.slot_out;
   assign rsp_doorbell_value = dec_ff.doorbell;
   assign rsp_accepted       = dec_ff.accepted;
   assign rsp_range_error    = dec_ff.range_error;
   assign rsp_slot_was_busy  = is_submit & flag_rd.in_flight;
   assign rsp_still_pending  = is_read & flag_rd.pending;
   assign rsp_in_flight      = is_read & flag_rd.in_flight;
   assign rsp_result_dword0  = is_read ? cpl_rd.dword0  : '0;
   assign rsp_result_sq_head = is_read ? cpl_rd.sq_head : '0;
   assign rsp_result_status  = is_read ? cpl_rd.status  : '0;

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   `NQPT_ASSERT_NEXT(a_rsp_single, clock, reset, rsp_valid, !rsp_valid, "result strobe held")
   `NQPT_ASSERT_NEXT(a_item_rsp, clock, reset, start && !busy, rsp_valid, "item without result")
   `NQPT_ASSERT_SAME(a_busy_ok, clock, reset, rsp_valid && rsp_slot_was_busy, rsp_accepted && !rsp_range_error, "busy flag on failed submit")
   `NQPT_ASSERT_SAME(a_clr_excl, clock, reset, clr_active_ff, !stage_valid_ff, "item taken during clear")

endmodule

`default_nettype wire

/* tb/nvme_queue_pair_tracker_monitor.sv */
module nvme_queue_pair_tracker_monitor
   import nqpt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic [1:0]  req_func,
   input  logic [1:0]  req_queue_id,
   input  logic [7:0]  req_slot,
   input  logic        req_cqe_phase,
   input  logic [1:0]  req_cqe_sq_id,
   input  logic [7:0]  req_cqe_cmd_id,
   input  logic [31:0] req_cqe_dword0,
   input  logic [15:0] req_cqe_sq_head,
   input  logic [14:0] req_cqe_status,
   input  logic        rsp_valid,
   input  logic [7:0]  rsp_slot_out,
   input  logic [7:0]  rsp_doorbell_value,
   input  logic        rsp_accepted,
   input  logic        rsp_range_error,
   input  logic        rsp_slot_was_busy,
   input  logic        rsp_still_pending,
   input  logic        rsp_in_flight,
   input  logic [31:0] rsp_result_dword0,
   input  logic [15:0] rsp_result_sq_head,
   input  logic [14:0] rsp_result_status,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [8:0]  csr_wdata,
   output int          mismatches,
   output int          outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PAIRS     = 4;
   localparam int SLOT_SPAN = 256;

   typedef struct packed {
      logic [7:0]  slot_out;
      logic [7:0]  doorbell;
      logic        accepted;
      logic        range_error;
      logic        was_busy;
      logic        pending;
      logic        in_flight;
      logic [31:0] dword0;
      logic [15:0] sq_head;
      logic [14:0] status;
   } slot_result;

   logic [8:0]  cfg_entries;
   logic [2:0]  cfg_pairs;
   logic [7:0]  sq_tail [PAIRS];
   logic [7:0]  cq_head [PAIRS];
   logic        cq_phase [PAIRS];
   bit          in_flight_map [PAIRS*SLOT_SPAN];
   bit          pending_map [PAIRS*SLOT_SPAN];
   logic [31:0] cpl_word [PAIRS*SLOT_SPAN];
   logic [15:0] cpl_head [PAIRS*SLOT_SPAN];
   logic [14:0] cpl_status [PAIRS*SLOT_SPAN];
   slot_result  expected_results [$];

   function automatic int ring_size();
      int e;
      e = cfg_entries;
      if (e < 2) e = 2;
      if (e > SLOT_SPAN) e = SLOT_SPAN;
      return e;
   endfunction

   function automatic int pair_count();
      int q;
      q = cfg_pairs;
      if (q < 1) q = 1;
      if (q > PAIRS) q = PAIRS;
      return q;
   endfunction

   function automatic logic [7:0] bump(int p, int e);
      return (p + 1 >= e) ? 8'd0 : 8'(p + 1);
   endfunction

   // Apply one item to the shadow state and return the result it should give.
   function automatic slot_result track_item(logic [1:0] fn, logic [1:0] q, logic [7:0] slot,
         logic phase, logic [1:0] csq, logic [7:0] ccid, logic [31:0] dw0,
         logic [15:0] head, logic [14:0] stat);
      slot_result r;
      int         e;
      int         nq;
      int         idx;
      r  = '0;
      e  = ring_size();
      nq = pair_count();
      if (q >= nq) begin
         r.range_error = 1'b1;
      end else begin
         case (func_type'(fn))
            FUNC_SUBMIT: begin
               idx = q * SLOT_SPAN + sq_tail[q];
               r.slot_out = sq_tail[q];
               r.was_busy = in_flight_map[idx];
               in_flight_map[idx] = 1'b1;
               pending_map[idx] = 1'b1;
               sq_tail[q] = bump(sq_tail[q], e);
               r.doorbell = sq_tail[q];
               r.accepted = 1'b1;
            end
            FUNC_CQE: begin
               if (phase == cq_phase[q]) begin
                  if (csq >= nq || ccid >= e) begin
                     r.range_error = 1'b1;
                  end else begin
                     idx = csq * SLOT_SPAN + ccid;
                     cpl_word[idx] = dw0;
                     cpl_head[idx] = head;
                     cpl_status[idx] = stat;
                     pending_map[idx] = 1'b0;
                  end
                  cq_head[q] = bump(cq_head[q], e);
                  if (cq_head[q] == 8'd0) cq_phase[q] = ~cq_phase[q];
                  r.doorbell = cq_head[q];
                  r.accepted = 1'b1;
               end
            end
            default: begin
               idx = q * SLOT_SPAN + slot;
               if (slot >= e) begin
                  r.range_error = 1'b1;
               end else if (func_type'(fn) == FUNC_RELEASE) begin
                  in_flight_map[idx] = 1'b0;
                  r.accepted = 1'b1;
               end else begin
                  r.slot_out  = slot;
                  r.accepted  = 1'b1;
                  r.pending   = pending_map[idx];
                  r.in_flight = in_flight_map[idx];
                  r.dword0    = cpl_word[idx];
                  r.sq_head   = cpl_head[idx];
                  r.status    = cpl_status[idx];
               end
            end
         endcase
      end
      return r;
   endfunction

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      slot_result want;
      if (reset) begin
         cfg_entries = 9'd256;
         cfg_pairs   = 3'd1;
         for (int i = 0; i < PAIRS; i++) begin
            sq_tail[i]  = 8'd0;
            cq_head[i]  = 8'd0;
            cq_phase[i] = 1'b1;
         end
         for (int i = 0; i < PAIRS * SLOT_SPAN; i++) begin
            in_flight_map[i] = 1'b0;
            pending_map[i]   = 1'b0;
            cpl_word[i]      = '0;
            cpl_head[i]      = '0;
            cpl_status[i]    = '0;
         end
         expected_results.delete();
         mismatches = 0;
         outstanding <= 0;
      end else begin
         if (rsp_valid) begin
            if (expected_results.size() == 0) begin
               $error("result strobe with no item outstanding");
               mismatches++;
            end else begin
               want = expected_results.pop_front();
               check_field("slot_out", want.slot_out, rsp_slot_out);
               check_field("doorbell_value", want.doorbell, rsp_doorbell_value);
               check_field("accepted", want.accepted, rsp_accepted);
               check_field("range_error", want.range_error, rsp_range_error);
               check_field("slot_was_busy", want.was_busy, rsp_slot_was_busy);
               check_field("still_pending", want.pending, rsp_still_pending);
               check_field("in_flight", want.in_flight, rsp_in_flight);
               check_field("result_dword0", want.dword0, rsp_result_dword0);
               check_field("result_sq_head", want.sq_head, rsp_result_sq_head);
               check_field("result_status", want.status, rsp_result_status);
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               CSR_QUEUE_ENTRIES: cfg_entries = csr_wdata;
               CSR_QUEUE_COUNT:   cfg_pairs = csr_wdata[2:0];
               default: ;
            endcase
         end
         if (start && !busy)
            expected_results.push_back(track_item(req_func, req_queue_id, req_slot,
               req_cqe_phase, req_cqe_sq_id, req_cqe_cmd_id, req_cqe_dword0,
               req_cqe_sq_head, req_cqe_status));
         outstanding <= expected_results.size();
      end
   end

endmodule

/* tb/nvme_queue_pair_tracker_test.sv */
module nvme_queue_pair_tracker_test;
   timeunit 1ns;
   timeprecision 1ps;

   import nqpt_pkg::*;

   localparam int RUN_LIMIT  = 100000;
   localparam int SLOT_SPAN  = 256;
   localparam int SETTINGS_N = 10;
   localparam int PHASE_LEN  = 184;

   // One queue operation as it goes onto the request ports.
   typedef struct {
      func_type    func;
      logic [1:0]  queue_id;
      logic [7:0]  slot;
      logic        phase;
      logic [1:0]  sq_id;
      logic [7:0]  cmd_id;
      logic [31:0] dword0;
      logic [15:0] sq_head;
      logic [14:0] status;
   } queue_cmd;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [1:0]  req_func;
   logic [1:0]  req_queue_id;
   logic [7:0]  req_slot;
   logic        req_cqe_phase;
   logic [1:0]  req_cqe_sq_id;
   logic [7:0]  req_cqe_cmd_id;
   logic [31:0] req_cqe_dword0;
   logic [15:0] req_cqe_sq_head;
   logic [14:0] req_cqe_status;
   logic        rsp_valid;
   logic [7:0]  rsp_slot_out;
   logic [7:0]  rsp_doorbell_value;
   logic        rsp_accepted;
   logic        rsp_range_error;
   logic        rsp_slot_was_busy;
   logic        rsp_still_pending;
   logic        rsp_in_flight;
   logic [31:0] rsp_result_dword0;
   logic [15:0] rsp_result_sq_head;
   logic [14:0] rsp_result_status;
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic [8:0]  csr_wdata;
   int          mismatches;
   int          outstanding;
   int          cycles = 0;

   // Stimulus-side view of the queues: just enough to build well-formed
   // command/completion sequences and to keep reads off never-written slots.
   int          ring_len = 256;
   int          pair_cnt = 1;
   int          idle_pct = 29;
   logic [7:0]  sq_next [4];
   logic [7:0]  cq_next [4];
   logic        cq_tag [4];
   bit          stored_map [4*SLOT_SPAN];
   int          stored_list [$];
   int          open_cmds [$];
   int          done_cmds [$];
   int          func_seen [4];

   nvme_queue_pair_tracker i_dut (.*);

   nvme_queue_pair_tracker_monitor i_tracker_monitor (.*);

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Watchdog: a hung handshake or a missing result ends the run here.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > RUN_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   function automatic int clamp(int v, int lo, int hi);
      return (v < lo) ? lo : (v > hi) ? hi : v;
   endfunction

   function automatic logic [7:0] wrap_next(logic [7:0] p);
      return (p + 1 >= ring_len) ? 8'd0 : 8'(p + 1);
   endfunction

   // Fill every field but operation, queue and slot at random so those request bits toggle, whatever the operation.
   function automatic queue_cmd make_cmd(func_type f, int q, int s);
      queue_cmd c;
      c.func     = f;
      c.queue_id = q;
      c.slot     = s;
      c.phase    = $urandom_range(1);
      c.sq_id    = $urandom_range(3);
      c.cmd_id   = $urandom_range(255);
      c.dword0   = $urandom;
      c.sq_head  = $urandom_range(16'hFFFF);
      c.status   = $urandom_range(15'h7FFF);
      return c;
   endfunction

   // Mostly well-formed traffic: submits, matching completions for open
   // commands, releases of completed ones and reads of stored slots; the rest
   // is noise (stray phases, bad ids, out-of-range queues and slots).
   function automatic queue_cmd random_cmd();
      queue_cmd c;
      int       pick;
      int       k;
      int       n;
      pick = $urandom_range(99);
      if (pick < 30) begin
         c = make_cmd(FUNC_SUBMIT, $urandom_range(3), $urandom_range(255));
         if ($urandom_range(9) != 0) c.queue_id = $urandom_range(pair_cnt - 1);
      end else if (pick < 60) begin
         c = make_cmd(FUNC_CQE, $urandom_range(3), $urandom_range(255));
         if (open_cmds.size() > 0 && $urandom_range(99) < 85) begin
            // complete mostly in order, sometimes out of order
            k = ($urandom_range(3) == 0) ? $urandom_range(open_cmds.size() - 1) : 0;
            n = open_cmds[k];
            open_cmds.delete(k);
            done_cmds.push_back(n);
            if (done_cmds.size() > 128) void'(done_cmds.pop_front());
            c.queue_id = n / SLOT_SPAN;
            c.sq_id    = c.queue_id;
            c.cmd_id   = n % SLOT_SPAN;
            c.phase    = cq_tag[c.queue_id];
         end else if ($urandom_range(3) != 0) begin
            c.queue_id = $urandom_range(pair_cnt - 1);
         end
      end else if (pick < 78) begin
         c = make_cmd(FUNC_RELEASE, $urandom_range(3), $urandom_range(255));
         if (done_cmds.size() > 0 && $urandom_range(4) != 0) begin
            k = $urandom_range(done_cmds.size() - 1);
            n = done_cmds[k];
            done_cmds.delete(k);
            c.queue_id = n / SLOT_SPAN;
            c.slot     = n % SLOT_SPAN;
         end
      end else begin
         c = make_cmd(FUNC_READ, $urandom_range(3), $urandom_range(255));
         // a read lands either on a stored slot or outside the configured range
         if (stored_list.size() > 0 && $urandom_range(9) != 0) begin
            n = stored_list[$urandom_range(stored_list.size() - 1)];
            c.queue_id = n / SLOT_SPAN;
            c.slot     = n % SLOT_SPAN;
         end else if (pair_cnt < 4 && $urandom_range(1) == 0) begin
            c.queue_id = $urandom_range(3, pair_cnt);
         end else if (ring_len < SLOT_SPAN) begin
            c.slot = $urandom_range(255, ring_len);
         end else if (pair_cnt < 4) begin
            c.queue_id = $urandom_range(3, pair_cnt);
         end else begin
            c.func = FUNC_RELEASE;
         end
      end
      return c;
   endfunction

   // Present one item, hold it until taken, then maybe idle for a while.
   task automatic send_item(queue_cmd c);
      int qi;
      int idx;
      qi = c.queue_id;
      if (qi < pair_cnt) begin
         if (c.func == FUNC_SUBMIT) begin
            open_cmds.push_back(qi * SLOT_SPAN + sq_next[qi]);
            if (open_cmds.size() > 128) void'(open_cmds.pop_front());
            sq_next[qi] = wrap_next(sq_next[qi]);
         end else if (c.func == FUNC_CQE && c.phase == cq_tag[qi]) begin
            if (c.sq_id < pair_cnt && c.cmd_id < ring_len) begin
               idx = c.sq_id * SLOT_SPAN + c.cmd_id;
               if (!stored_map[idx]) begin
                  stored_map[idx] = 1'b1;
                  stored_list.push_back(idx);
               end
            end
            cq_next[qi] = wrap_next(cq_next[qi]);
            if (cq_next[qi] == 8'd0) cq_tag[qi] = ~cq_tag[qi];
         end
      end
      func_seen[c.func]++;
      req_func        <= c.func;
      req_queue_id    <= c.queue_id;
      req_slot        <= c.slot;
      req_cqe_phase   <= c.phase;
      req_cqe_sq_id   <= c.sq_id;
      req_cqe_cmd_id  <= c.cmd_id;
      req_cqe_dword0  <= c.dword0;
      req_cqe_sq_head <= c.sq_head;
      req_cqe_status  <= c.status;
      start           <= 1'b1;
      do @(posedge clock); while (busy);
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   // Write ring size then queue count back to back, valid held high across both.
   task automatic program_config(logic [8:0] entries_val, logic [8:0] count_val);
      csr_index <= CSR_QUEUE_ENTRIES;
      csr_wdata <= entries_val;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_index <= CSR_QUEUE_COUNT;
      csr_wdata <= count_val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      ring_len = clamp(entries_val, 2, SLOT_SPAN);
      pair_cnt = clamp(count_val[2:0], 1, 4);
   endtask

   // Drop start and wait until every item has produced its result.
   task automatic drain();
      start <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   initial begin
      queue_cmd   c;
      logic [8:0] ring_vals [SETTINGS_N];
      logic [8:0] pair_vals [SETTINGS_N];

      // Settings walk through the clamp extremes (0, 1, 2, 256, 511 entries;
      // count 0 and above four) and set the upper write-data bits for the count.
      ring_vals = '{9'd2, 9'd0, 9'd4, 9'h1FF, 9'd17, 9'd1, 9'd256, 9'd3, 9'd255, 9'd8};
      pair_vals = '{9'h004, 9'h1F8, 9'h003, 9'h002, 9'h007, 9'h0A4, 9'h004, 9'h001,
                    9'h106, 9'h002};
      for (int i = 0; i < 4; i++) begin
         sq_next[i]   = 8'd0;
         cq_next[i]   = 8'd0;
         cq_tag[i]    = 1'b1;
         func_seen[i] = 0;
      end
      reset           = 1'b1;
      start           = 1'b0;
      req_func        = '0;
      req_queue_id    = '0;
      req_slot        = '0;
      req_cqe_phase   = 1'b0;
      req_cqe_sq_id   = '0;
      req_cqe_cmd_id  = '0;
      req_cqe_dword0  = '0;
      req_cqe_sq_head = '0;
      req_cqe_status  = '0;
      csr_valid       = 1'b0;
      csr_index       = CSR_QUEUE_ENTRIES;
      csr_wdata       = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed pass at the reset setting: 256 entries, one queue pair.
      // The first item simply waits out the flag-clearing sweep on busy.
      send_item(make_cmd(FUNC_SUBMIT, 0, 0));
      c = make_cmd(FUNC_CQE, 0, 0);
      c.phase = 1'b1; c.sq_id = 0; c.cmd_id = 0;
      c.dword0 = '1; c.sq_head = '1; c.status = '1;
      send_item(c);
      send_item(make_cmd(FUNC_READ, 0, 0));
      send_item(make_cmd(FUNC_RELEASE, 0, 0));
      send_item(make_cmd(FUNC_READ, 0, 0));
      send_item(make_cmd(FUNC_SUBMIT, 0, 0));
      // queue beyond the configured count
      send_item(make_cmd(FUNC_SUBMIT, 3, 0));
      // stale phase tag: entry ignored
      c = make_cmd(FUNC_CQE, 0, 0);
      c.phase = 1'b0;
      send_item(c);
      // entry naming a queue that is not in use: consumed, nothing stored
      c = make_cmd(FUNC_CQE, 0, 0);
      c.phase = 1'b1; c.sq_id = 2;
      send_item(c);
      c = make_cmd(FUNC_CQE, 0, 0);
      c.phase = 1'b1; c.sq_id = 0; c.cmd_id = 255;
      c.dword0 = '0; c.sq_head = '0; c.status = '0;
      send_item(c);
      send_item(make_cmd(FUNC_READ, 0, 255));
      send_item(make_cmd(FUNC_RELEASE, 0, 255));
      send_item(make_cmd(FUNC_READ, 1, 0));
      send_item(make_cmd(FUNC_RELEASE, 2, 3));
      drain();

      // Random phases, one per setting; the small rings force head/tail wraps,
      // phase flips and busy slots, and the first one wraps stale pointers.
      for (int p = 0; p < SETTINGS_N; p++) begin
         program_config(ring_vals[p], pair_vals[p]);
         idle_pct = (p == 3) ? 0 : 29;
         repeat (PHASE_LEN) send_item(random_cmd());
         drain();
      end

      repeat (8) @(posedge clock);
      $display("Ran %0d items: %0d submits, %0d completion entries, %0d releases, %0d reads",
               func_seen[FUNC_SUBMIT] + func_seen[FUNC_CQE] + func_seen[FUNC_RELEASE]
               + func_seen[FUNC_READ], func_seen[FUNC_SUBMIT], func_seen[FUNC_CQE],
               func_seen[FUNC_RELEASE], func_seen[FUNC_READ]);
      $display("over %0d ring/queue settings, %0d distinct slots holding completions",
               SETTINGS_N + 1, stored_list.size());
      if (mismatches == 0 && outstanding == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
